// ===== rtl/ccr_pkg.sv =====
// Shared types and constants for the quarter-circle rasterizer.
package ccr_pkg;

   // Field widths
   localparam int CoordW = 13;  // center coordinate
   localparam int PixW   = 14;  // plotted pixel coordinate
   localparam int RadW   = 5;   // radius
   localparam int QuadW  = 2;   // quadrant selector

   // Stepper arithmetic widths
   localparam int OffW   = 7;   // signed offsets, oy reaches -1
   localparam int ErrW   = 12;  // signed error term
   localparam int CountW = 6;   // pixel counter

   localparam int MaxRadius  = 31;
   localparam int ResultCap  = 64;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   // Quadrant codes: offset signs applied to (x, y)
   localparam logic [QuadW-1:0] QuadPxNy = 2'd0;
   localparam logic [QuadW-1:0] QuadPxPy = 2'd1;
   localparam logic [QuadW-1:0] QuadNxPy = 2'd2;
   localparam logic [QuadW-1:0] QuadNxNy = 2'd3;

   // One classified draw job
   typedef struct packed {
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic                     neg_x;
      logic                     neg_y;
      logic [RadW-1:0]          radius;
   } job_type;

   // Front to queue
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // Queue status toward front and back
   typedef struct packed {
      logic    full;
      logic    not_empty;
      job_type head;
   } queue_status_type;

endpackage

// ===== rtl/circle_quadrant_rasterizer.sv =====
// Top level of the quarter-circle rasterizer.
//
//   channel | direction | tdata                          | tuser    | tlast
//   req     | in        | center_x, center_y, radius     | quadrant | -
//   rsp     | out       | pixel_x, pixel_y               | -        | last_pixel
//
// A request of radius r yields 2r+1 or fewer pixel words, one per cycle while
// rsp_tready is high; the stepper loop (one step per emitted pixel) sets this.
// A job passes through a queue slot before stepping starts; up to two jobs
// queue behind the one in progress. reset is synchronous and drops all jobs.
// A stall on rsp holds the output word and freezes the stepper; req keeps
// accepting until the queue is full.
module circle_quadrant_rasterizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // center_x[12:0], center_y[25:13], radius[30:26], zero
   input  logic [1:0]  req_tuser,  // quadrant[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // pixel_x[13:0], pixel_y[27:14], zero
   output logic        rsp_tlast   // last_pixel
);

   ccr_pkg::push_type                push;
   ccr_pkg::queue_status_type        status;
   logic                             pop;
   logic signed [ccr_pkg::PixW-1:0]  pixel_x;
   logic signed [ccr_pkg::PixW-1:0]  pixel_y;

   assign req_tready = !status.full && !reset;

   ccr_front u_front (
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push)
   );

   ccr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   ccr_stepper u_stepper (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .last_pixel (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, pixel_y, pixel_x};

endmodule

// ===== rtl/ccr_front.sv =====
// Request front end: unpacks a request word and classifies it into a job.
module ccr_front (
   input  logic                        req_tvalid,
   input  logic                        req_ready,
   input  logic [31:0]                 req_tdata,  // center_x, center_y, radius, pad
   input  logic [ccr_pkg::QuadW-1:0]   req_tuser,  // quadrant
   output ccr_pkg::push_type           push
);

   logic [ccr_pkg::RadW-1:0] radius;
   logic [ccr_pkg::RadW-1:0] radius_sat;

   // Unpack and clamp radius
   assign radius     = req_tdata[30:26];
   assign radius_sat = (radius > ccr_pkg::RadW'(ccr_pkg::MaxRadius))
                       ? ccr_pkg::RadW'(ccr_pkg::MaxRadius) : radius;

   // Build job, signs from quadrant
   always_comb begin
      push.valid          = req_tvalid && req_ready;
      push.job.center_x   = $signed(req_tdata[12:0]);
      push.job.center_y   = $signed(req_tdata[25:13]);
      push.job.radius     = radius_sat;
      push.job.neg_x      = (req_tuser == ccr_pkg::QuadNxPy) ||
                            (req_tuser == ccr_pkg::QuadNxNy);
      push.job.neg_y      = (req_tuser == ccr_pkg::QuadPxNy) ||
                            (req_tuser == ccr_pkg::QuadNxNy);
   end

endmodule

// ===== rtl/ccr_queue.sv =====
// Short job queue between front end and stepper.
module ccr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ccr_pkg::push_type         push,
   input  logic                      pop,
   output ccr_pkg::queue_status_type status
);

   ccr_pkg::job_type               slot_ff [ccr_pkg::QueueDepth];
   logic [ccr_pkg::QueuePtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ccr_pkg::QueuePtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ccr_pkg::QueueCntW-1:0]  count_ff, count_in;
   logic                           do_push, do_pop;

   assign do_push = push.valid && (count_ff != ccr_pkg::QueueCntW'(ccr_pkg::QueueDepth));
   assign do_pop  = pop && (count_ff != '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign status.full      = (count_ff == ccr_pkg::QueueCntW'(ccr_pkg::QueueDepth));
   assign status.not_empty = (count_ff != '0);
   assign status.head      = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/ccr_stepper.sv =====
// Back end: Bresenham circle stepper with registered pixel output.
module ccr_stepper (
   input  logic                           clock,
   input  logic                           reset,
   input  ccr_pkg::queue_status_type      status,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic signed [ccr_pkg::PixW-1:0] pixel_x,
   output logic signed [ccr_pkg::PixW-1:0] pixel_y,
   output logic                           last_pixel
);

   localparam int OffW = ccr_pkg::OffW;
   localparam int ErrW = ccr_pkg::ErrW;
   localparam int PixW = ccr_pkg::PixW;

   logic                      busy_ff, busy_in;
   ccr_pkg::job_type          job_ff, job_in;
   logic signed [OffW-1:0]    ox_ff, ox_in;
   logic signed [OffW-1:0]    oy_ff, oy_in;
   logic signed [ErrW-1:0]    d_ff, d_in;
   logic [ccr_pkg::CountW-1:0] count_ff, count_in;
   logic                      valid_ff, valid_in;
   logic signed [PixW-1:0]    px_ff, px_in;
   logic signed [PixW-1:0]    py_ff, py_in;
   logic                      last_ff, last_in;

   logic                      emit;
   logic signed [ErrW-1:0]    dy;
   logic signed [ErrW:0]      e;
   logic signed [OffW-1:0]    ox_inc, oy_dec;
   logic signed [OffW-1:0]    ox_step, oy_step;
   logic signed [ErrW-1:0]    d_step;
   logic                      is_last;
   logic signed [PixW-1:0]    cx_ext, cy_ext, ox_ext, oy_ext;

   assign emit = busy_ff && (!valid_ff || rsp_tready);
   assign pop  = !busy_ff && status.not_empty;

   // Next offsets and error term for one step
   always_comb begin
      dy     = d_ff + ErrW'(oy_ff);
      e      = $signed({dy, 1'b0}) - (ErrW+1)'(1);
      ox_inc = ox_ff + OffW'(1);
      oy_dec = oy_ff - OffW'(1);
      if (d_ff < 0 && e <= 0) begin
         ox_step = ox_inc;
         oy_step = oy_ff;
         d_step  = d_ff + (ErrW'(ox_inc) <<< 1) + ErrW'(1);
      end else if (d_ff > 0 && e > 0) begin
         ox_step = ox_ff;
         oy_step = oy_dec;
         d_step  = d_ff - ((ErrW'(oy_dec) <<< 1) + ErrW'(1));
      end else begin
         ox_step = ox_inc;
         oy_step = oy_dec;
         d_step  = d_ff + (ErrW'(ox_inc - oy_ff) <<< 1);
      end
      is_last = (oy_step < 0) ||
                (count_ff == ccr_pkg::CountW'(ccr_pkg::ResultCap - 1));
   end

   // Current pixel operands, widened to pixel width; quadrant signs applied below
   always_comb begin
      cx_ext = PixW'(job_ff.center_x);
      cy_ext = PixW'(job_ff.center_y);
      ox_ext = PixW'(ox_ff);
      oy_ext = PixW'(oy_ff);
   end

   // Sequencing: load a job, then one pixel per free output slot
   always_comb begin
      busy_in  = busy_ff;
      job_in   = job_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      d_in     = d_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;
      if (pop) begin
         busy_in  = 1'b1;
         job_in   = status.head;
         ox_in    = '0;
         oy_in    = OffW'(status.head.radius);
         d_in     = ErrW'(1) - (ErrW'(status.head.radius) <<< 1);
         count_in = '0;
      end
      if (emit) begin
         valid_in = 1'b1;
         px_in    = job_ff.neg_x ? cx_ext - ox_ext : cx_ext + ox_ext;
         py_in    = job_ff.neg_y ? cy_ext - oy_ext : cy_ext + oy_ext;
         last_in  = is_last;
         ox_in    = ox_step;
         oy_in    = oy_step;
         d_in     = d_step;
         count_in = count_ff + 1'b1;
         busy_in  = !is_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      job_ff   <= job_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      d_ff     <= d_in;
      count_ff <= count_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign last_pixel = last_ff;

endmodule

// ===== rtl/ccr_checker.sv =====
// Port-level checks for the quarter-circle rasterizer, bound to the top level.
module ccr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Stalled output word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Queue fills only by accepting a request
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("req_tready dropped without an accepted word");

   // Padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:28] == 4'b0000)
      else $error("rsp_tdata padding not zero");

endmodule

bind circle_quadrant_rasterizer ccr_checker u_ccr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
